// ===== hw/rtl/estm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler scale transform matrix core.
`timescale 1ns / 1ps

package estm_pkg;

  // Pipeline shape
  localparam int SIN_STAGES  = 8;   // sine unit register stages
  localparam int DIV_BITS    = 4;   // quotient bits resolved per divider stage
  localparam int DIV_LAST    = 9;   // stage that holds the finished quotient
  localparam int ROT_STAGE   = 10;  // stage that holds the rotation entries
  localparam int PIPE_STAGES = 12;  // stage that drives the output channel

  // Sine polynomial coefficients, Q30, lowest order first
  localparam logic [30:0] SIN_COEF [6] = '{
    31'd1686629713, 31'd693598669, 31'd85569305, 31'd5026994, 31'd172272, 31'd3864
  };

  localparam logic [32:0] RECIP_SAT = 33'h0_FFFF_FFFF;  // reciprocal of a zero scale
  localparam logic [15:0] QUARTER   = 16'd16384;        // quarter turn

  typedef enum logic {
    MODE_MODEL  = 1'b0,
    MODE_NORMAL = 1'b1
  } mode_t;

  typedef struct packed {
    logic               action;
    logic        [15:0] angle_x;
    logic        [15:0] angle_y;
    logic        [15:0] angle_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
  } xform_t;

  typedef struct packed {
    logic signed [31:0] c0_r0;
    logic signed [31:0] c0_r1;
    logic signed [31:0] c0_r2;
    logic signed [31:0] c1_r0;
    logic signed [31:0] c1_r1;
    logic signed [31:0] c1_r2;
    logic signed [31:0] c2_r0;
    logic signed [31:0] c2_r1;
    logic signed [31:0] c2_r2;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } matrix_t;

  // Side data that rides along with the trig and divide work
  typedef struct packed {
    logic                  normal;
    logic [2:0]            neg;
    logic [2:0][15:0]      smag;
    logic [2:0][31:0]      move;
  } side_t;

  // Q30 x Q30 product, floored back to Q30
  function automatic logic signed [33:0] mul30(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  // Bit of the rounded reciprocal numerator 2^32 + smag/2
  function automatic logic num_bit(logic [15:0] smag, logic [5:0] idx);
    logic [32:0] num;
    num = {1'b1, 17'd0, smag[15:1]};
    return num[idx];
  endfunction

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [16:0] div_step(logic [15:0] rem, logic nbit, logic [15:0] dvs);
    logic [16:0] trial;
    logic [16:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      return {1'b1, diff[15:0]};
    end
    return {1'b0, trial[15:0]};
  endfunction

  // Shift, round half away from zero, apply sign and saturate to Q16.16
  function automatic logic [31:0] finish_entry(logic [63:0] prod, logic neg, logic normal);
    logic [42:0] res;
    logic [42:0] negres;
    if (normal) begin
      res = 43'(prod >> 38) + 43'(prod[37]);
    end else begin
      res = 43'(prod >> 22) + 43'(prod[21]);
    end
    negres = -res;
    if (res == 43'd0) begin
      return 32'd0;
    end
    if (neg) begin
      if (res >= 43'h0_8000_0000) begin
        return 32'h8000_0000;
      end
      return negres[31:0];
    end
    if (res > 43'h0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end
    return res[31:0];
  endfunction

endpackage

// ===== hw/rtl/estm_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per transfer.
`timescale 1ns / 1ps

interface estm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/estm_sin.sv =====
// Pipelined Q30 sine unit: quadrant fold, odd polynomial by Horner steps.
`timescale 1ns / 1ps

module estm_sin (
  input  logic                                clk,
  input  logic [estm_pkg::SIN_STAGES-1:0]     en,     // en[i] loads stage i+1
  input  logic [15:0]                         angle,
  output logic signed [31:0]                  value
);

  localparam int LastStage = estm_pkg::SIN_STAGES;

  logic [30:0] u    [1:LastStage-1];
  logic        neg  [1:LastStage-1];
  logic [30:0] u2   [2:LastStage-2];
  logic [30:0] poly [3:LastStage-1];

  // Stage 1: fold into the first quadrant
  logic [14:0] rfold;
  always_comb begin
    if (angle[14]) begin
      rfold = 15'(estm_pkg::QUARTER) - {1'b0, angle[13:0]};
    end else begin
      rfold = {1'b0, angle[13:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u[1]   <= {rfold, 16'd0};
      neg[1] <= angle[15];
    end
  end

  // Stage 2: u squared
  logic [61:0] sq;
  assign sq = u[1] * u[1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      u2[2] <= sq[60:30];
    end
  end

  // Carry u, sign and u^2 down the pipe
  for (genvar s = 2; s < LastStage; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[s-1]) begin
        u[s]   <= u[s-1];
        neg[s] <= neg[s-1];
      end
    end
    if (s >= 3 && s <= LastStage - 2) begin : g_u2
      always_ff @(posedge clk) begin
        if (en[s-1]) begin
          u2[s] <= u2[s-1];
        end
      end
    end
  end

  // Stages 3..7: p = coef - u^2 * p
  for (genvar s = 3; s < LastStage; s++) begin : g_horner
    logic [30:0] prev;
    logic [61:0] term;
    if (s == 3) begin : g_first
      assign prev = estm_pkg::SIN_COEF[5];
    end else begin : g_next
      assign prev = poly[s-1];
    end
    assign term = u2[s-1] * prev;
    always_ff @(posedge clk) begin
      if (en[s-1]) begin
        poly[s] <= estm_pkg::SIN_COEF[7-s] - term[60:30];
      end
    end
  end

  // Last stage: multiply by u, clamp to one, apply quadrant sign
  logic [61:0] fin;
  logic [31:0] mag;
  assign fin = u[LastStage-1] * poly[LastStage-1];
  always_comb begin
    mag = fin[61:30];
    if (mag > 32'h4000_0000) begin
      mag = 32'h4000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LastStage-1]) begin
      value <= neg[LastStage-1] ? -mag : mag;
    end
  end

endmodule

// ===== hw/rtl/euler_scale_transform_matrix_core.sv =====
// Top level: Euler angle rotation times scale (or inverse scale) matrix pipeline.
//
// Usage:
//   xform  (sink)   : one transform per transfer: mode, Y/X/Z angles, scales, move.
//   matrix (source) : the 3x3 rotation-scale entries column by column and offsets.
//   One result leaves for every item taken, in order. Action 0 gives the model
//   matrix with the move passed through; action 1 gives the normal matrix with
//   each column multiplied by the reciprocal of its scale and zero offsets.
//
// Timing:
//   Twelve register stages; one item per cycle is sustained while the
//   receiver is ready. The depth is set by the eight-stage sine units, two
//   stages of rotation products, one scale product stage and the rounding /
//   saturation stage; the reciprocal divider (one bit in stage 1, then 4 bits
//   per stage) runs beside the sine units and the first rotation stage.
//
// Reset clears all stage valid bits; payload registers hold stale data.
// When the receiver stalls, a full stage holds only while the one after it holds, so
// bubbles are squeezed out and input is still taken until all stages are full.
`timescale 1ns / 1ps

module euler_scale_transform_matrix_core (
  input logic                 clk,
  input logic                 rst,
  estm_stream_if.sink         xform,
  estm_stream_if.source       matrix
);

  localparam int NS = estm_pkg::PIPE_STAGES;
  localparam int DL = estm_pkg::DIV_LAST;
  localparam int RS = estm_pkg::ROT_STAGE;

  // Stage flow control
  logic [NS:1] vld;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !vld[NS] || matrix.ready;
    for (int i = NS - 1; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign xform.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= xform.valid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Sines and cosines (s1/c1 from Y, s2/c2 from X, s3/c3 from Z)
  logic signed [31:0] s1, c1, s2, c2, s3, c3;
  logic [15:0] ay, ax, az;
  assign ay = xform.data.angle_y;
  assign ax = xform.data.angle_x;
  assign az = xform.data.angle_z;

  estm_sin u_s1 (.clk(clk), .en(en[8:1]), .angle(ay),                      .value(s1));
  estm_sin u_c1 (.clk(clk), .en(en[8:1]), .angle(ay + estm_pkg::QUARTER), .value(c1));
  estm_sin u_s2 (.clk(clk), .en(en[8:1]), .angle(ax),                      .value(s2));
  estm_sin u_c2 (.clk(clk), .en(en[8:1]), .angle(ax + estm_pkg::QUARTER), .value(c2));
  estm_sin u_s3 (.clk(clk), .en(en[8:1]), .angle(az),                      .value(s3));
  estm_sin u_c3 (.clk(clk), .en(en[8:1]), .angle(az + estm_pkg::QUARTER), .value(c3));

  // Side data: mode, scale sign and magnitude, move
  estm_pkg::side_t side [1:RS];
  estm_pkg::side_t side_in;
  logic signed [2:0][15:0] scl;
  logic        [2:0][16:0] sneg;

  always_comb begin
    scl[0] = xform.data.scale_x;
    scl[1] = xform.data.scale_y;
    scl[2] = xform.data.scale_z;
    side_in.normal  = (xform.data.action == estm_pkg::MODE_NORMAL);
    side_in.move[0] = xform.data.move_x;
    side_in.move[1] = xform.data.move_y;
    side_in.move[2] = xform.data.move_z;
    for (int a = 0; a < 3; a++) begin
      sneg[a]         = -{scl[a][15], scl[a]};
      side_in.neg[a]  = scl[a][15];
      side_in.smag[a] = scl[a][15] ? sneg[a][15:0] : scl[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side[1] <= side_in;
    end
    for (int i = 2; i <= RS; i++) begin
      if (en[i]) begin
        side[i] <= side[i-1];
      end
    end
  end

  // Reciprocal divider: 2^32 + smag/2 over smag, restoring, one bit at stage 1
  logic [2:0][15:0] rem [1:DL-1];
  logic [2:0][32:0] quo [1:DL];
  logic [2:0][16:0] first;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      first[a] = estm_pkg::div_step(16'd0, 1'b1, side_in.smag[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        rem[1][a] <= first[a][15:0];
        quo[1][a] <= {first[a][16], 32'd0};
      end
    end
  end

  for (genvar s = 2; s <= DL; s++) begin : g_div
    logic [2:0][15:0] rn;
    logic [2:0][32:0] qn;
    always_comb begin
      logic [16:0] step;
      logic [5:0]  idx;
      rn = rem[s-1];
      qn = quo[s-1];
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < estm_pkg::DIV_BITS; b++) begin
          idx  = 6'(31 - estm_pkg::DIV_BITS * (s - 2) - b);
          step = estm_pkg::div_step(rn[a], estm_pkg::num_bit(side[s-1].smag[a], idx),
                                    side[s-1].smag[a]);
          qn[a][idx] = step[16];
          rn[a]      = step[15:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        quo[s] <= qn;
      end
    end
    // The remainder is only carried while quotient bits remain
    if (s < DL) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem[s] <= rn;
        end
      end
    end
  end

  // Stage 9: first-level rotation products
  logic signed [31:0] c1c3, s1s2, c1s2, c3s1, c1s3, c2s3, c2c3, s1s3, c2s1, c1c2;
  logic signed [31:0] s2_9, s3_9;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      c1c3 <= 32'(estm_pkg::mul30(c1, c3));
      s1s2 <= 32'(estm_pkg::mul30(s1, s2));
      c1s2 <= 32'(estm_pkg::mul30(c1, s2));
      c3s1 <= 32'(estm_pkg::mul30(c3, s1));
      c1s3 <= 32'(estm_pkg::mul30(c1, s3));
      c2s3 <= 32'(estm_pkg::mul30(c2, s3));
      c2c3 <= 32'(estm_pkg::mul30(c2, c3));
      s1s3 <= 32'(estm_pkg::mul30(s1, s3));
      c2s1 <= 32'(estm_pkg::mul30(c2, s1));
      c1c2 <= 32'(estm_pkg::mul30(c1, c2));
      s2_9 <= s2;
      s3_9 <= s3;
    end
  end

  // Stage 10: rotation entries, scale multiplier selection
  logic signed [33:0] rot [9];
  logic [2:0][32:0]   mag;
  logic [2:0]         mneg;
  logic [2:0][32:0]   mag_n;
  logic [2:0]         mneg_n;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mneg_n[a] = side[DL].neg[a];
      if (!side[DL].normal) begin
        mag_n[a] = {17'd0, side[DL].smag[a]};
      end else if (side[DL].smag[a] == 16'd0) begin
        mag_n[a]  = estm_pkg::RECIP_SAT;
        mneg_n[a] = 1'b0;
      end else begin
        mag_n[a] = quo[DL][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[RS]) begin
      rot[0] <= 34'(c1c3) + estm_pkg::mul30(s1s2, s3_9);
      rot[1] <= 34'(c2s3);
      rot[2] <= estm_pkg::mul30(c1s2, s3_9) - 34'(c3s1);
      rot[3] <= estm_pkg::mul30(c3s1, s2_9) - 34'(c1s3);
      rot[4] <= 34'(c2c3);
      rot[5] <= estm_pkg::mul30(c1c3, s2_9) + 34'(s1s3);
      rot[6] <= 34'(c2s1);
      rot[7] <= -34'(s2_9);
      rot[8] <= 34'(c1c2);
      mag    <= mag_n;
      mneg   <= mneg_n;
    end
  end

  // Stage 11: entry times scale magnitude (32x32 plus the 2^32 top bit)
  logic [63:0] prod [9];
  logic [8:0]  pneg;
  logic        normal11;
  logic [2:0][31:0] move11;

  for (genvar e = 0; e < 9; e++) begin : g_prod
    localparam int Col = e / 3;
    logic [33:0] rneg;
    logic [31:0] rm;
    logic [63:0] pp;
    assign rneg = -rot[e];
    assign rm   = rot[e][33] ? rneg[31:0] : rot[e][31:0];
    assign pp   = 64'(rm) * 64'(mag[Col][31:0]);
    always_ff @(posedge clk) begin
      if (en[11]) begin
        prod[e] <= pp + (mag[Col][32] ? {rm, 32'd0} : 64'd0);
        pneg[e] <= rot[e][33] ^ mneg[Col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      normal11 <= side[RS].normal;
      move11   <= side[RS].move;
    end
  end

  // Stage 12: round, saturate, output register
  logic [31:0] ent [9];
  estm_pkg::matrix_t out_q;
  logic normal12;

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      ent[e] = estm_pkg::finish_entry(prod[e], pneg[e], normal11);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      out_q.c0_r0    <= ent[0];
      out_q.c0_r1    <= ent[1];
      out_q.c0_r2    <= ent[2];
      out_q.c1_r0    <= ent[3];
      out_q.c1_r1    <= ent[4];
      out_q.c1_r2    <= ent[5];
      out_q.c2_r0    <= ent[6];
      out_q.c2_r1    <= ent[7];
      out_q.c2_r2    <= ent[8];
      out_q.offset_x <= normal11 ? 32'd0 : move11[0];
      out_q.offset_y <= normal11 ? 32'd0 : move11[1];
      out_q.offset_z <= normal11 ? 32'd0 : move11[2];
      normal12       <= normal11;
    end
  end

  assign matrix.valid = vld[NS];
  assign matrix.data  = out_q;

  // Input is refused only when every stage holds an item
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !xform.ready |-> (&vld))
    else $error("input refused while a stage is empty");

  // Reset empties the pipe
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("stage valid bits not cleared by reset");

  // Normal-matrix results carry zero offsets
  a_normal_offsets: assert property (@(posedge clk) disable iff (rst)
    (matrix.valid && normal12) |->
      (matrix.data.offset_x == 32'd0 && matrix.data.offset_y == 32'd0 &&
       matrix.data.offset_z == 32'd0))
    else $error("normal matrix with nonzero offset");

  // A taken result followed by a bubble leaves the output empty
  a_bubble_drains: assert property (@(posedge clk) disable iff (rst)
    (vld[NS] && matrix.ready && !vld[NS-1]) |=> !matrix.valid)
    else $error("result repeated after transfer");

endmodule

// ===== test/tb_euler_scale_transform_matrix_core.sv =====
// Testbench for the Euler scale transform matrix core: random and directed transforms.
`timescale 1ns / 1ps

module tb_euler_scale_transform_matrix_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;

  estm_stream_if #(.T(estm_pkg::xform_t))  xform_ch ();
  estm_stream_if #(.T(estm_pkg::matrix_t)) matrix_ch ();

  euler_scale_transform_matrix_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .xform  (xform_ch.sink),
    .matrix (matrix_ch.source)
  );

  estm_pkg::matrix_t expected_matrices[$];
  int      mismatches;
  int      sent_count;
  int      got_count;
  int      normal_count;
  int      cycle_count;
  int      sink_wait;
  bit      hold_off;
  bit      sink_gaps;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Q30 product floored back to Q30
  function automatic longint q30_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  // Sine of a 16-bit angle in Q30 via odd polynomial per quadrant
  function automatic longint sine_q30(logic [15:0] ang);
    longint coef[6];
    longint u;
    longint u2;
    longint p;
    logic [1:0] quad;
    logic [14:0] r;
    coef = '{1686629713, 693598669, 85569305, 5026994, 172272, 3864};
    quad = ang[15:14];
    r = {1'b0, ang[13:0]};
    if (quad[0]) begin
      r = 15'd16384 - r;
    end
    u = longint'(r) << 16;
    u2 = q30_mul(u, u);
    p = coef[5];
    for (int i = 4; i >= 0; i--) begin
      p = coef[i] - q30_mul(u2, p);
    end
    p = q30_mul(u, p);
    if (p < 0) p = 0;
    if (p > 64'sd1073741824) p = 64'sd1073741824;
    return quad[1] ? -p : p;
  endfunction

  // Rotation entry times a signed magnitude, rounded half away and saturated
  function automatic logic [31:0] scaled_entry(longint rot, longint unsigned mag, bit neg,
                                               int sh);
    longint unsigned rm;
    longint unsigned prod;
    longint unsigned res;
    rm = (rot < 0) ? longint'(-rot) : longint'(rot);
    if (rot < 0) neg = !neg;
    prod = rm * mag;
    res = (prod >> sh) + ((prod >> (sh - 1)) & 1);
    if (res == 0) return 32'd0;
    if (neg) begin
      if (res >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(64'h1_0000_0000 - res);
    end
    if (res > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return res[31:0];
  endfunction

  // Predicts the matrix for one transform
  function automatic estm_pkg::matrix_t predict_matrix(estm_pkg::xform_t x);
    longint s1, c1, s2, c2, s3, c3;
    longint rot[9];
    logic [31:0] ent[9];
    logic signed [15:0] sc[3];
    longint unsigned smag;
    longint unsigned mag;
    bit neg;
    bit normal;
    int sh;
    estm_pkg::matrix_t m;
    normal = (x.action == estm_pkg::MODE_NORMAL);
    s2 = sine_q30(x.angle_x);
    c2 = sine_q30(x.angle_x + estm_pkg::QUARTER);
    s1 = sine_q30(x.angle_y);
    c1 = sine_q30(x.angle_y + estm_pkg::QUARTER);
    s3 = sine_q30(x.angle_z);
    c3 = sine_q30(x.angle_z + estm_pkg::QUARTER);
    rot[0] = q30_mul(c1, c3) + q30_mul(q30_mul(s1, s2), s3);
    rot[1] = q30_mul(c2, s3);
    rot[2] = q30_mul(q30_mul(c1, s2), s3) - q30_mul(c3, s1);
    rot[3] = q30_mul(q30_mul(c3, s1), s2) - q30_mul(c1, s3);
    rot[4] = q30_mul(c2, c3);
    rot[5] = q30_mul(q30_mul(c1, c3), s2) + q30_mul(s1, s3);
    rot[6] = q30_mul(c2, s1);
    rot[7] = -s2;
    rot[8] = q30_mul(c1, c2);
    sc = '{x.scale_x, x.scale_y, x.scale_z};
    for (int k = 0; k < 3; k++) begin
      neg = sc[k] < 0;
      smag = neg ? longint'(-longint'(sc[k])) : longint'(sc[k]);
      if (normal) begin
        if (smag == 0) begin
          mag = 64'hFFFF_FFFF;
          neg = 1'b0;
        end else begin
          mag = (64'h1_0000_0000 + (smag >> 1)) / smag;
        end
        sh = 38;
      end else begin
        mag = smag;
        sh = 22;
      end
      for (int j = 0; j < 3; j++) begin
        ent[k * 3 + j] = scaled_entry(rot[k * 3 + j], mag, neg, sh);
      end
    end
    m.c0_r0 = ent[0]; m.c0_r1 = ent[1]; m.c0_r2 = ent[2];
    m.c1_r0 = ent[3]; m.c1_r1 = ent[4]; m.c1_r2 = ent[5];
    m.c2_r0 = ent[6]; m.c2_r1 = ent[7]; m.c2_r2 = ent[8];
    m.offset_x = normal ? 32'd0 : x.move_x;
    m.offset_y = normal ? 32'd0 : x.move_y;
    m.offset_z = normal ? 32'd0 : x.move_z;
    return m;
  endfunction

  // Sends one transform and records its expected matrix; valid stays up on return
  task automatic send_xform(estm_pkg::xform_t x, bit gaps = 1'b1);
    int wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 12) : 0;
    if (wait_cycles > 0) begin
      xform_ch.valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    xform_ch.valid <= 1'b1;
    xform_ch.data  <= x;
    do @(posedge clk); while (!xform_ch.ready);
    expected_matrices.push_back(predict_matrix(x));
    sent_count++;
    if (x.action == estm_pkg::MODE_NORMAL) normal_count++;
  endtask

  // Drops valid after the last transfer of a series
  task automatic idle_input();
    xform_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic estm_pkg::xform_t random_xform();
    estm_pkg::xform_t x;
    x.action  = 1'($urandom_range(0, 1));
    x.angle_x = 16'($urandom);
    x.angle_y = 16'($urandom);
    x.angle_z = 16'($urandom);
    x.scale_x = ($urandom_range(0, 9) == 0) ? 16'sd0 : 16'($urandom);
    x.scale_y = ($urandom_range(0, 9) == 0) ? 16'sd0 : 16'($urandom);
    x.scale_z = ($urandom_range(0, 9) == 0) ? 16'sd0 : 16'($urandom);
    // each scale is near unit scale half the time, where entries stay in range
    if ($urandom_range(0, 1)) x.scale_x = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
    if ($urandom_range(0, 1)) x.scale_y = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
    if ($urandom_range(0, 1)) x.scale_z = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
    x.move_x  = $urandom;
    x.move_y  = $urandom;
    x.move_z  = $urandom;
    return x;
  endfunction

  // Receiver: waits a drawn number of cycles per result or holds off; checks each transfer
  always @(posedge clk) begin
    if (rst) begin
      matrix_ch.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (matrix_ch.valid && matrix_ch.ready) begin
        if (expected_matrices.size() == 0) begin
          $error("unexpected matrix transfer");
          mismatches++;
        end else begin
          estm_pkg::matrix_t e;
          estm_pkg::matrix_t a;
          e = expected_matrices.pop_front();
          a = matrix_ch.data;
          got_count++;
          if (a.c0_r0 !== e.c0_r0) begin $error("c0_r0 exp %0d got %0d", e.c0_r0, a.c0_r0); mismatches++; end
          if (a.c0_r1 !== e.c0_r1) begin $error("c0_r1 exp %0d got %0d", e.c0_r1, a.c0_r1); mismatches++; end
          if (a.c0_r2 !== e.c0_r2) begin $error("c0_r2 exp %0d got %0d", e.c0_r2, a.c0_r2); mismatches++; end
          if (a.c1_r0 !== e.c1_r0) begin $error("c1_r0 exp %0d got %0d", e.c1_r0, a.c1_r0); mismatches++; end
          if (a.c1_r1 !== e.c1_r1) begin $error("c1_r1 exp %0d got %0d", e.c1_r1, a.c1_r1); mismatches++; end
          if (a.c1_r2 !== e.c1_r2) begin $error("c1_r2 exp %0d got %0d", e.c1_r2, a.c1_r2); mismatches++; end
          if (a.c2_r0 !== e.c2_r0) begin $error("c2_r0 exp %0d got %0d", e.c2_r0, a.c2_r0); mismatches++; end
          if (a.c2_r1 !== e.c2_r1) begin $error("c2_r1 exp %0d got %0d", e.c2_r1, a.c2_r1); mismatches++; end
          if (a.c2_r2 !== e.c2_r2) begin $error("c2_r2 exp %0d got %0d", e.c2_r2, a.c2_r2); mismatches++; end
          if (a.offset_x !== e.offset_x) begin
            $error("offset_x exp %0d got %0d", e.offset_x, a.offset_x); mismatches++;
          end
          if (a.offset_y !== e.offset_y) begin
            $error("offset_y exp %0d got %0d", e.offset_y, a.offset_y); mismatches++;
          end
          if (a.offset_z !== e.offset_z) begin
            $error("offset_z exp %0d got %0d", e.offset_z, a.offset_z); mismatches++;
          end
        end
      end
      if (hold_off) begin
        matrix_ch.ready <= 1'b0;
      end else if (sink_gaps) begin
        // new wait drawn after each transfer, counted down while ready is low
        if (matrix_ch.valid && matrix_ch.ready) begin
          sink_wait = $urandom_range(0, 12);
        end else if (sink_wait > 0) begin
          sink_wait--;
        end
        matrix_ch.ready <= (sink_wait == 0);
      end else begin
        matrix_ch.ready <= 1'b1;
      end
    end
  end

  // Corners of angles, scales, moves and both modes
  task automatic test_directed();
    logic [15:0] angles[8];
    logic signed [15:0] scales[6];
    estm_pkg::xform_t x;
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000, 16'h3FFF, 16'h0001};
    scales = '{16'sh0000, 16'sh0100, -16'sh0100, 16'sh8000, 16'sh7FFF, 16'sh0001};
    for (int i = 0; i < 24; i++) begin
      x.action  = i[0];
      x.angle_x = angles[i % 8];
      x.angle_y = angles[(i + 3) % 8];
      x.angle_z = angles[(i + 5) % 8];
      x.scale_x = scales[i % 6];
      x.scale_y = scales[(i + 2) % 6];
      x.scale_z = scales[(i + 4) % 6];
      x.move_x  = (i % 3 == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      x.move_y  = (i % 3 == 1) ? 32'shFFFF_FFFF : 32'sh0;
      x.move_z  = $urandom;
      send_xform(x);
    end
  endtask

  // Random transforms with gaps on both sides
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_xform(random_xform());
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_xform(random_xform(), 1'b0);
    join
    idle_input();
  endtask

  // Full rate with the receiver always ready
  task automatic test_streaming();
    sink_gaps = 1'b0;
    for (int i = 0; i < 200; i++) send_xform(random_xform(), 1'b0);
    idle_input();
    sink_gaps = 1'b1;
  endtask

  initial begin
    int drain;
    mismatches = 0;
    sent_count = 0;
    got_count = 0;
    normal_count = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    sink_gaps = 1'b1;
    rst = 1'b1;
    xform_ch.valid = 1'b0;
    xform_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    test_streaming();
    test_random(690);
    idle_input();
    drain = 0;
    while (expected_matrices.size() != 0) @(posedge clk);
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    $display("Sent %0d transforms (%0d normal-matrix), checked %0d matrices.",
             sent_count, normal_count, got_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
